@@ src/aia_pkg.sv @@
// ----------------------------------------------------------------------------
// aia_pkg
// Shared types and operation codes for the accumulator integer ALU.
// ----------------------------------------------------------------------------
package aia_pkg;

  localparam int unsigned XLEN  = 64;
  localparam int unsigned HLEN  = 32;
  localparam int unsigned KLEN  = 5;
  localparam int unsigned NCELL = XLEN;

  typedef enum logic [KLEN-1:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_XOR   = 5'd2,
    OP_OR    = 5'd3,
    OP_AND   = 5'd4,
    OP_SLL   = 5'd5,
    OP_SRL   = 5'd6,
    OP_SRA   = 5'd7,
    OP_SLT   = 5'd8,
    OP_SLTU  = 5'd9,
    OP_MUL   = 5'd10,
    OP_MULH  = 5'd11,
    OP_MULSU = 5'd12,
    OP_MULU  = 5'd13,
    OP_DIV   = 5'd14,
    OP_DIVU  = 5'd15,
    OP_REM   = 5'd16,
    OP_REMU  = 5'd17
  } op_t;

  typedef struct packed {
    logic            valid;
    logic [KLEN-1:0] kind;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] pp_ll;
    logic [HLEN-1:0] pp_x;
  } front_t;

  typedef struct packed {
    logic            valid;
    logic            is_div;
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic            dz;
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quot;
    logic [XLEN-1:0] dvsr;
  } cell_data_t;

endpackage

@@ src/accumulator_integer_alu_top.sv @@
// ----------------------------------------------------------------------------
// accumulator_integer_alu_top
// 64-bit integer ALU: two front stages, a row of 64 divide cells, output stage.
// ----------------------------------------------------------------------------
// Every operation, divide or not, runs through all stages from input transaction to result.
// Throughput: one transaction per cycle; the whole row advances together
// and holds only while the output register is full and not taken.
// Reset: synchronous rst clears all valid bits; no other state.
module accumulator_integer_alu_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // target_value[63:0], operand_value[127:64]
  input  logic [4:0]    s_tuser,   // kind[4:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,   // result_value[63:0]
  output logic          m_tuser    // divide_by_zero[0]
);

  logic                adv;
  aia_pkg::cell_data_t chain [aia_pkg::NCELL+1];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  aia_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_a     (s_tdata[63:0]),
    .in_b     (s_tdata[127:64]),
    .out_data (chain[0])
  );

  for (genvar i = 0; i < aia_pkg::NCELL; i++) begin : g_cell
    aia_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_data  (chain[i]),
      .out_data (chain[i+1])
    );
  end

  aia_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_data   (chain[aia_pkg::NCELL]),
    .out_valid (m_tvalid),
    .out_value (m_tdata),
    .out_dz    (m_tuser)
  );

endmodule

@@ src/aia_prep.sv @@
// ----------------------------------------------------------------------------
// aia_prep
// Two front stages: partial products, then simple results and divide setup.
// ----------------------------------------------------------------------------
module aia_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [aia_pkg::KLEN-1:0]    in_kind,
  input  logic [aia_pkg::XLEN-1:0]    in_a,
  input  logic [aia_pkg::XLEN-1:0]    in_b,
  output aia_pkg::cell_data_t         out_data
);

  aia_pkg::front_t     front;
  aia_pkg::front_t     front_next;
  aia_pkg::cell_data_t prep_next;
  logic [aia_pkg::XLEN-1:0] prod;
  logic [aia_pkg::HLEN-1:0] prod_hi;
  logic [5:0]               sh;
  logic                     is_signed;

  always_comb begin
    front_next.valid = in_valid;
    front_next.kind  = in_kind;
    front_next.a     = in_a;
    front_next.b     = in_b;
    front_next.pp_ll = {32'd0, in_a[31:0]} * {32'd0, in_b[31:0]};
    front_next.pp_x  = in_a[31:0] * in_b[63:32] + in_a[63:32] * in_b[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (adv) begin
      front.valid <= front_next.valid;
    end
    if (adv) begin
      front.kind  <= front_next.kind;
      front.a     <= front_next.a;
      front.b     <= front_next.b;
      front.pp_ll <= front_next.pp_ll;
      front.pp_x  <= front_next.pp_x;
    end
  end

  always_comb begin
    prod      = front.pp_ll + {front.pp_x, 32'd0};
    prod_hi   = prod[63:32];
    sh        = front.b[5:0];
    is_signed = (front.kind == aia_pkg::OP_DIV) || (front.kind == aia_pkg::OP_REM);
    prep_next.valid    = front.valid;
    prep_next.is_div   = 1'b0;
    prep_next.want_rem = (front.kind == aia_pkg::OP_REM) || (front.kind == aia_pkg::OP_REMU);
    prep_next.neg_q    = is_signed && (front.a[63] ^ front.b[63]);
    prep_next.neg_r    = is_signed && front.a[63];
    prep_next.dz       = 1'b0;
    prep_next.rem      = '0;
    prep_next.quot     = (is_signed && front.a[63]) ? (64'd0 - front.a) : front.a;
    prep_next.dvsr     = (is_signed && front.b[63]) ? (64'd0 - front.b) : front.b;
    case (front.kind)
      aia_pkg::OP_ADD:   prep_next.res = front.a + front.b;
      aia_pkg::OP_SUB:   prep_next.res = front.a - front.b;
      aia_pkg::OP_XOR:   prep_next.res = front.a ^ front.b;
      aia_pkg::OP_OR:    prep_next.res = front.a | front.b;
      aia_pkg::OP_AND:   prep_next.res = front.a & front.b;
      aia_pkg::OP_SLL:   prep_next.res = front.a << sh;
      aia_pkg::OP_SRL:   prep_next.res = front.a >> sh;
      aia_pkg::OP_SRA:   prep_next.res = 64'($signed(front.a) >>> sh);
      aia_pkg::OP_SLT:   prep_next.res = {63'd0, $signed(front.a) < $signed(front.b)};
      aia_pkg::OP_SLTU:  prep_next.res = {63'd0, front.a < front.b};
      aia_pkg::OP_MUL:   prep_next.res = {32'd0, prod[31:0]};
      aia_pkg::OP_MULH:  prep_next.res = {{32{prod_hi[31]}}, prod_hi};
      aia_pkg::OP_MULSU,
      aia_pkg::OP_MULU:  prep_next.res = {32'd0, prod_hi};
      aia_pkg::OP_DIV,
      aia_pkg::OP_DIVU,
      aia_pkg::OP_REM,
      aia_pkg::OP_REMU: begin
        prep_next.res    = '0;
        prep_next.is_div = (front.b != '0);
        prep_next.dz     = (front.b == '0);
      end
      default:           prep_next.res = front.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_data.valid <= 1'b0;
    end else if (adv) begin
      out_data.valid <= prep_next.valid;
    end
    if (adv) begin
      out_data.is_div   <= prep_next.is_div;
      out_data.want_rem <= prep_next.want_rem;
      out_data.neg_q    <= prep_next.neg_q;
      out_data.neg_r    <= prep_next.neg_r;
      out_data.dz       <= prep_next.dz;
      out_data.res      <= prep_next.res;
      out_data.rem      <= prep_next.rem;
      out_data.quot     <= prep_next.quot;
      out_data.dvsr     <= prep_next.dvsr;
    end
  end

endmodule

@@ src/aia_div_cell.sv @@
// ----------------------------------------------------------------------------
// aia_div_cell
// One restoring divide step: shift in one dividend bit, subtract, keep.
// ----------------------------------------------------------------------------
module aia_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  aia_pkg::cell_data_t in_data,
  output aia_pkg::cell_data_t out_data
);

  logic [aia_pkg::XLEN:0] rem_sh;
  logic [aia_pkg::XLEN:0] diff;
  aia_pkg::cell_data_t    step_next;

  always_comb begin
    rem_sh    = {in_data.rem, in_data.quot[aia_pkg::XLEN-1]};
    diff      = rem_sh - {1'b0, in_data.dvsr};
    step_next = in_data;
    if (!diff[aia_pkg::XLEN]) begin
      step_next.rem  = diff[aia_pkg::XLEN-1:0];
      step_next.quot = {in_data.quot[aia_pkg::XLEN-2:0], 1'b1};
    end else begin
      step_next.rem  = rem_sh[aia_pkg::XLEN-1:0];
      step_next.quot = {in_data.quot[aia_pkg::XLEN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_data.valid <= 1'b0;
    end else if (adv) begin
      out_data.valid <= step_next.valid;
    end
    if (adv) begin
      out_data.is_div   <= step_next.is_div;
      out_data.want_rem <= step_next.want_rem;
      out_data.neg_q    <= step_next.neg_q;
      out_data.neg_r    <= step_next.neg_r;
      out_data.dz       <= step_next.dz;
      out_data.res      <= step_next.res;
      out_data.rem      <= step_next.rem;
      out_data.quot     <= step_next.quot;
      out_data.dvsr     <= step_next.dvsr;
    end
  end

endmodule

@@ src/aia_post.sv @@
// ----------------------------------------------------------------------------
// aia_post
// Sign fixup of divide results, result select and output register.
// ----------------------------------------------------------------------------
module aia_post (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  aia_pkg::cell_data_t       in_data,
  output logic                      out_valid,
  output logic [aia_pkg::XLEN-1:0]  out_value,
  output logic                      out_dz
);

  logic [aia_pkg::XLEN-1:0] q_fix;
  logic [aia_pkg::XLEN-1:0] r_fix;
  logic [aia_pkg::XLEN-1:0] value_next;

  always_comb begin
    q_fix = in_data.neg_q ? (64'd0 - in_data.quot) : in_data.quot;
    r_fix = in_data.neg_r ? (64'd0 - in_data.rem) : in_data.rem;
    if (in_data.is_div) begin
      value_next = in_data.want_rem ? r_fix : q_fix;
    end else begin
      value_next = in_data.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_data.valid;
    end
    if (adv) begin
      out_value <= value_next;
      out_dz    <= in_data.dz;
    end
  end

endmodule

@@ src/aia_checker.sv @@
// ----------------------------------------------------------------------------
// aia_checker
// Port-level checks for the accumulator integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module aia_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [63:0]   m_tdata,
  input logic          m_tuser
);

  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
    else $error("divide by zero result not zero");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output space");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind accumulator_integer_alu_top aia_checker u_aia_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
